// File: rtl/fps_pkg.sv
// Shared types and constants for the flash page scan and select block.
`timescale 1ns / 1ps
package fps_pkg;

    localparam logic [31:0] SUM_SEED          = 32'h9E37_79B9;
    localparam logic [31:0] MAGIC_RESET       = 32'h4348_3445;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd4080;
    localparam int          HEADER_BYTES      = 16;
    localparam logic [16:0] POS_MAX           = 17'h1_FFFF;

    // Configuration register indexes
    localparam logic REG_MAGIC_WORD  = 1'b0;
    localparam logic REG_MAX_PAYLOAD = 1'b1;

    typedef enum logic [2:0] {
        VERDICT_VALID     = 3'd0,
        VERDICT_BAD_MAGIC = 3'd1,
        VERDICT_BAD_SIZE  = 3'd2,
        VERDICT_BAD_SUM   = 3'd3,
        VERDICT_TRUNCATED = 3'd4
    } verdict_t;

    // Page state after the current byte has been folded in
    typedef struct packed {
        logic [17:0] count;
        logic [31:0] magic;
        logic [31:0] serial;
        logic [31:0] size;
        logic [31:0] check;
        logic [31:0] sum;
    } page_info_t;

    typedef struct packed {
        logic [3:0]  page_number;
        verdict_t    verdict;
        logic        found;
        logic [3:0]  best_page;
        logic [31:0] lead_serial;
        logic        scan_done;
    } page_result_t;

endpackage

// File: rtl/fps_parse.sv
// Header capture, byte position and payload checksum for one page.
`timescale 1ns / 1ps
module fps_parse (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                page_first,
    input  logic                page_last,
    output fps_pkg::page_info_t info
);
    import fps_pkg::*;

    logic [16:0] pos_reg, pos_next;
    logic [31:0] magic_reg, magic_next;
    logic [31:0] serial_reg, serial_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] check_reg, check_next;
    logic [31:0] sum_reg, sum_next;

    logic [16:0] pos;
    logic [16:0] pos_off;
    logic [31:0] magic_b, serial_b, size_b, check_b, sum_b;
    logic [31:0] lane_val;

    always_comb
    begin
        // A page_first byte restarts parsing mid-page
        pos      = page_first ? '0 : pos_reg;
        magic_b  = page_first ? '0 : magic_reg;
        serial_b = page_first ? '0 : serial_reg;
        size_b   = page_first ? '0 : size_reg;
        check_b  = page_first ? '0 : check_reg;
        sum_b    = page_first ? '0 : sum_reg;

        lane_val = 32'(data_byte) << {pos[1:0], 3'b000};
        pos_off  = pos - 17'(HEADER_BYTES);

        magic_next  = magic_b;
        serial_next = serial_b;
        size_next   = size_b;
        check_next  = check_b;
        sum_next    = sum_b;

        if (pos < 17'(HEADER_BYTES))
        begin
            case (pos[3:2])
                2'd0:    magic_next  = magic_b | lane_val;
                2'd1:    serial_next = serial_b | lane_val;
                2'd2:    size_next   = size_b | lane_val;
                default: check_next  = check_b | lane_val;
            endcase
            if (pos == 17'(HEADER_BYTES - 1))
                sum_next = SUM_SEED ^ serial_b;
        end
        else if (32'(pos_off) < size_b)
        begin
            // rotate left by one, then add the byte
            sum_next = {sum_b[30:0], sum_b[31]} + 32'(data_byte);
        end

        pos_next = (pos < POS_MAX) ? pos + 17'd1 : pos;

        info.count  = 18'(pos) + 18'd1;
        info.magic  = magic_next;
        info.serial = serial_next;
        info.size   = size_next;
        info.check  = check_next;
        info.sum    = sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            magic_reg  <= '0;
            serial_reg <= '0;
            size_reg   <= '0;
            check_reg  <= '0;
            sum_reg    <= '0;
        end
        else if (step)
        begin
            if (page_last)
            begin
                pos_reg    <= '0;
                magic_reg  <= '0;
                serial_reg <= '0;
                size_reg   <= '0;
                check_reg  <= '0;
                sum_reg    <= '0;
            end
            else
            begin
                pos_reg    <= pos_next;
                magic_reg  <= magic_next;
                serial_reg <= serial_next;
                size_reg   <= size_next;
                check_reg  <= check_next;
                sum_reg    <= sum_next;
            end
        end
    end

endmodule

// File: rtl/fps_judge.sv
// Page verdict, best page tracking and page counter.
`timescale 1ns / 1ps
module fps_judge #(
    parameter int PAGE_COUNT = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  page_last,
    input  logic                  scan_last,
    input  fps_pkg::page_info_t   info,
    input  logic [31:0]           magic_word,
    input  logic [15:0]           max_payload,
    output fps_pkg::page_result_t result
);
    import fps_pkg::*;

    localparam logic [3:0] LAST_PAGE = 4'(PAGE_COUNT - 1);

    logic [3:0]  page_cnt_reg, page_cnt_next;
    logic        best_valid_reg, best_valid_next;
    logic [3:0]  best_index_reg, best_index_next;
    logic [31:0] lead_serial_reg, lead_serial_next;

    verdict_t    verdict;
    logic [32:0] need_count;

    always_comb
    begin
        need_count = 33'(info.size) + 33'(HEADER_BYTES);

        if (info.count < 18'(HEADER_BYTES))
            verdict = VERDICT_TRUNCATED;
        else if (info.magic != magic_word)
            verdict = VERDICT_BAD_MAGIC;
        else if (info.size == '0 || info.size > 32'(max_payload))
            verdict = VERDICT_BAD_SIZE;
        else if (33'(info.count) < need_count)
            verdict = VERDICT_TRUNCATED;
        else if (info.sum != info.check)
            verdict = VERDICT_BAD_SUM;
        else
            verdict = VERDICT_VALID;

        best_valid_next  = best_valid_reg;
        best_index_next  = best_index_reg;
        lead_serial_next = lead_serial_reg;
        // strictly higher serial wins; a tie keeps the earlier page
        if (verdict == VERDICT_VALID &&
            (!best_valid_reg || info.serial > lead_serial_reg))
        begin
            best_valid_next  = 1'b1;
            best_index_next  = page_cnt_reg;
            lead_serial_next = info.serial;
        end

        page_cnt_next = (page_cnt_reg >= LAST_PAGE) ? '0 : page_cnt_reg + 4'd1;

        result.page_number = page_cnt_reg;
        result.verdict     = verdict;
        result.found       = best_valid_next;
        result.best_page   = best_index_next;
        result.lead_serial = lead_serial_next;
        result.scan_done   = scan_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_cnt_reg    <= '0;
            best_valid_reg  <= 1'b0;
            best_index_reg  <= '0;
            lead_serial_reg <= '0;
        end
        else if (step && page_last)
        begin
            if (scan_last)
            begin
                page_cnt_reg    <= '0;
                best_valid_reg  <= 1'b0;
                best_index_reg  <= '0;
                lead_serial_reg <= '0;
            end
            else
            begin
                page_cnt_reg    <= page_cnt_next;
                best_valid_reg  <= best_valid_next;
                best_index_reg  <= best_index_next;
                lead_serial_reg <= lead_serial_next;
            end
        end
    end

endmodule

// File: rtl/flash_page_scan_select_top.sv
// Top level of the flash page scan and select block.
//
// Usage: stream the bytes of every stored page on the slave channel, one item
// per byte, header first. tlast marks the last byte of a page; tuser[0] marks
// the first byte of a page and tuser[1], together with tlast, closes the scan.
// For each page the master channel gives one result item: the page number,
// its verdict, and the best valid page (highest serial, earlier page on a tie)
// seen so far. The result's tlast is high on the item that closes the scan;
// the best page fields are final there and the scan state clears after it.
// Throughput: one byte per cycle, except while a page's closing byte waits (see Stall).
// A result passes the input register, then the result register, to m_tvalid.
// Stall: the result register holds while m_tready is low; the input register
// keeps taking header and payload bytes, and stops at a page's closing byte
// until the pending result has been taken.
// Reset: the parser, the page counter and the best page clear; magic_word
// returns to 0x43483445 and max_payload to 4080.
// Configuration: cfg_we with cfg_index 0 writes magic_word, 1 writes
// max_payload (low 16 bits of cfg_data); write only while the block is idle.
`timescale 1ns / 1ps
module flash_page_scan_select_top #(
    parameter int PAGE_COUNT = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [0] page_first, [1] scan_last
    input  logic        s_tlast,   // page_last
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] page_number, [6:4] verdict, [7] found, [11:8] best_page,
    // [43:12] lead_serial, [47:44] zero
    output logic [47:0] m_tdata,
    output logic        m_tlast    // scan_done
);
    import fps_pkg::*;

    // Configuration registers
    logic [31:0] magic_word_reg;
    logic [15:0] max_payload_reg;

    // Input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_first_reg;
    logic        in_last_reg;
    logic        in_scan_last_reg;

    // Result register
    logic         out_valid_reg, out_valid_next;
    page_result_t out_reg;

    page_info_t   info;
    page_result_t result;
    logic         s_accept;
    logic         step;

    // Advance the held byte unless it closes a page while a result still waits
    assign step     = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_word_reg  <= MAGIC_RESET;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAGIC_WORD:  magic_word_reg  <= cfg_data;
                REG_MAX_PAYLOAD: max_payload_reg <= cfg_data[15:0];
                default:         magic_word_reg  <= magic_word_reg;
            endcase
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step && in_last_reg)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load without reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg      <= s_tdata;
            in_first_reg     <= s_tuser[0];
            in_last_reg      <= s_tlast;
            in_scan_last_reg <= s_tuser[1];
        end
        if (step && in_last_reg)
            out_reg <= result;
    end

    fps_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .data_byte  (in_byte_reg),
        .page_first (in_first_reg),
        .page_last  (in_last_reg),
        .info       (info)
    );

    fps_judge #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_judge (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .page_last   (in_last_reg),
        .scan_last   (in_scan_last_reg),
        .info        (info),
        .magic_word  (magic_word_reg),
        .max_payload (max_payload_reg),
        .result      (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.lead_serial, out_reg.best_page, out_reg.found,
                       out_reg.verdict, out_reg.page_number};
    assign m_tlast  = out_reg.scan_done;

endmodule

// File: rtl/fps_checker.sv
// Port-level checks for the flash page scan and select block, bound to the top.
`timescale 1ns / 1ps
module fps_checker #(
    parameter int PAGE_COUNT = 2
) (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast
);
    import fps_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_valid_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[6:4] == VERDICT_VALID |-> m_tdata[7])
        else $error("valid page reported without found");

    a_empty_best: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[7] |-> m_tdata[11:8] == 4'd0 && m_tdata[43:12] == 32'd0)
        else $error("best page fields set without found");

    a_page_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> 32'(m_tdata[3:0]) < PAGE_COUNT && 32'(m_tdata[11:8]) < PAGE_COUNT
                     && m_tdata[6:4] <= VERDICT_TRUNCATED)
        else $error("page index or verdict out of range");

endmodule

bind flash_page_scan_select_top fps_checker #(
    .PAGE_COUNT (PAGE_COUNT)
) u_fps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: tb/tb.sv
// Self-checking testbench for the flash page scan and select block.
`timescale 1ns / 1ps
module tb;
    import fps_pkg::*;

    // Page slots of the block under test; the page index wraps after this many
    localparam int PAGES = 2;
    // Cycles without any accepted item before the run is declared hung
    localparam int STALL_LIMIT = 4000;
    // Length of the receiver's long hold-off, in cycles
    localparam int HOLD_CYCLES = 400;
    // Cycles to let the block settle once nothing is expected (two-stage pipe)
    localparam int SETTLE_CYCLES = 8;

    // One byte of page stream plus its sideband, and the idle cycles before it
    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       scan_end;
        int         gap;
    } flash_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;

    flash_page_scan_select_top #(
        .PAGE_COUNT(PAGES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Bytes waiting to be driven, and page verdicts waiting to come out
    flash_byte_t  byte_queue[$];
    page_result_t verdict_queue[$];
    page_result_t verdict_head;

    int bytes_built;
    int bytes_offered;
    int bytes_taken;
    int results_taken;
    int mismatches;
    int quiet_cycles;
    int sender_gap_max;
    int send_idle;

    // Receiver pacing: per-result wait, calm stretches and the long hold-off
    int hold_requests;
    int hold_served;
    int hold_left;
    int rx_seen;
    int rx_idle;
    int rx_gap;
    int rx_run;
    bit rx_calm;

    // Scanner shadow: page parse, scan-wide best page and the two registers
    logic [16:0] pos_q;
    logic [31:0] hdr_magic;
    logic [31:0] hdr_serial;
    logic [31:0] hdr_size;
    logic [31:0] hdr_check;
    logic [31:0] csum;
    logic [3:0]  page_idx;
    logic        have_best;
    logic [3:0]  best_idx;
    logic [31:0] best_ser;
    logic [31:0] cfg_magic;
    logic [15:0] cfg_max;

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic restart_page_state();
        pos_q      = '0;
        hdr_magic  = '0;
        hdr_serial = '0;
        hdr_size   = '0;
        hdr_check  = '0;
        csum       = '0;
    endtask

    task automatic clear_scan_state();
        page_idx  = '0;
        have_best = 1'b0;
        best_idx  = '0;
        best_ser  = '0;
    endtask

    // Fold one accepted byte into the shadow; queue a verdict on a page's last byte
    task automatic fold_byte(input logic [7:0] b, input logic first, input logic last,
                             input logic scan_end);
        logic [16:0]  p;
        logic [31:0]  lane;
        logic [32:0]  cnt;
        logic [32:0]  need;
        page_result_t r;
        if (first)
            restart_page_state();
        p = pos_q;
        if (p < 17'(HEADER_BYTES))
        begin
            lane = {24'b0, b} << (8 * p[1:0]);
            case (p[3:2])
                2'd0:    hdr_magic  |= lane;
                2'd1:    hdr_serial |= lane;
                2'd2:    hdr_size   |= lane;
                default: hdr_check  |= lane;
            endcase
            // Seed the sum from the complete serial on the last header byte
            if (p == 17'(HEADER_BYTES - 1))
                csum = SUM_SEED ^ hdr_serial;
        end
        else if ({15'b0, p} - 32'(HEADER_BYTES) < hdr_size)
        begin
            csum = {csum[30:0], csum[31]} + {24'b0, b};
        end
        cnt = {16'b0, p} + 33'd1;
        if (p < POS_MAX)
            pos_q = p + 17'd1;
        if (!last)
            return;

        need = 33'(HEADER_BYTES) + {1'b0, hdr_size};
        if (cnt < 33'(HEADER_BYTES))
            r.verdict = VERDICT_TRUNCATED;
        else if (hdr_magic != cfg_magic)
            r.verdict = VERDICT_BAD_MAGIC;
        else if (hdr_size == 32'd0 || hdr_size > {16'b0, cfg_max})
            r.verdict = VERDICT_BAD_SIZE;
        else if (cnt < need)
            r.verdict = VERDICT_TRUNCATED;
        else if (csum != hdr_check)
            r.verdict = VERDICT_BAD_SUM;
        else
            r.verdict = VERDICT_VALID;

        // Strictly higher serial wins; a tie keeps the earlier page
        if (r.verdict == VERDICT_VALID && (!have_best || hdr_serial > best_ser))
        begin
            have_best = 1'b1;
            best_idx  = page_idx;
            best_ser  = hdr_serial;
        end
        r.page_number = page_idx;
        r.found       = have_best;
        r.best_page   = best_idx;
        r.lead_serial = best_ser;
        r.scan_done   = scan_end;
        verdict_queue.push_back(r);

        restart_page_state();
        if (scan_end)
            clear_scan_state();
        else if (32'(page_idx) + 1 >= PAGES)
            page_idx = '0;
        else
            page_idx = page_idx + 4'd1;
    endtask

    // Build one page: header, then body_len random bytes; cut > 0 sends only
    // that many bytes, close marks the final byte sent as the page's last
    task automatic add_page(input logic [31:0] magic, input logic [31:0] serial,
                            input logic [31:0] size, input int body_len, input int cut,
                            input bit close, input bit spoil, input bit scan_end,
                            input bit mark_first);
        logic [7:0]   body[$];
        logic [127:0] hdr;
        logic [31:0]  sum;
        flash_byte_t  fb;
        int           n;
        sum = SUM_SEED ^ serial;
        for (int i = 0; i < body_len; i++)
        begin
            body.push_back(8'($urandom));
            if (i < size)
                sum = {sum[30:0], sum[31]} + {24'b0, body[i]};
        end
        if (spoil)
            sum ^= 32'd1 << $urandom_range(31, 0);
        hdr = {sum, size, serial, magic};
        n = (cut > 0) ? cut : HEADER_BYTES + body_len;
        for (int i = 0; i < n; i++)
        begin
            fb.data     = (i < HEADER_BYTES) ? hdr[8*i +: 8] : body[i - HEADER_BYTES];
            fb.first    = (i == 0) && mark_first;
            fb.last     = close && (i == n - 1);
            // scan_last away from a page end must be ignored
            fb.scan_end = fb.last ? scan_end : ($urandom_range(7, 0) == 0);
            fb.gap      = $urandom_range(sender_gap_max, 0);
            byte_queue.push_back(fb);
        end
        bytes_built += n;
    endtask

    task automatic add_good(input logic [31:0] serial, input logic [31:0] size,
                            input int extra, input bit scan_end);
        add_page(cfg_magic, serial, size, int'(size) + extra, 0, 1, 0, scan_end, 1);
    endtask

    // Loose bytes with random sideband
    task automatic add_noise(input int count);
        flash_byte_t fb;
        for (int i = 0; i < count; i++)
        begin
            fb.data     = 8'($urandom);
            fb.first    = ($urandom_range(3, 0) == 0);
            fb.last     = ($urandom_range(3, 0) == 0);
            fb.scan_end = 1'($urandom_range(1, 0));
            fb.gap      = $urandom_range(sender_gap_max, 0);
            byte_queue.push_back(fb);
        end
        bytes_built += count;
    endtask

    // Small serials make ties common; the extremes show up often too
    function automatic logic [31:0] pick_serial();
        case ($urandom_range(3, 0))
            0, 1:    return 32'($urandom_range(3, 0));
            2:       return $urandom_range(1, 0) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed pages with random content, plus broken pages and noise
    task automatic run_random(input int budget);
        int         goal;
        int         kind;
        int         lim;
        int         size;
        int         run_len;
        logic [31:0] bad_size;
        goal    = bytes_built + budget;
        run_len = 0;
        while (bytes_built < goal)
        begin
            if (run_len == 0)
            begin
                sender_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 5;
                run_len        = $urandom_range(12, 4);
            end
            run_len--;
            lim  = (cfg_max < 16'd12) ? int'(cfg_max) : 12;
            size = $urandom_range(lim, 1);
            kind = $urandom_range(19, 0);
            case (kind)
                11, 12:
                    add_page(cfg_magic, pick_serial(), size, size, 0, 1, 1,
                             $urandom_range(5, 0) == 0, 1);
                13:
                    add_page(cfg_magic ^ (32'd1 << $urandom_range(31, 0)), pick_serial(),
                             size, size, 0, 1, 0, $urandom_range(5, 0) == 0, 1);
                14:
                begin
                    bad_size = $urandom_range(1, 0) ? 32'd0
                             : {16'b0, cfg_max} + 32'd1 + 32'($urandom_range(100, 0));
                    add_page(cfg_magic, pick_serial(), bad_size, $urandom_range(4, 0), 0, 1, 0,
                             $urandom_range(5, 0) == 0, 1);
                end
                15:
                    add_page(cfg_magic, pick_serial(), size, $urandom_range(size - 1, 0), 0,
                             1, 0, $urandom_range(5, 0) == 0, 1);
                16:
                    add_page(cfg_magic, pick_serial(), size, size, $urandom_range(15, 1), 1, 0,
                             $urandom_range(5, 0) == 0, 1);
                17:
                begin
                    // Abandon a page mid-stream; the next page_first restarts parsing
                    add_page(cfg_magic, pick_serial(), size, size,
                             $urandom_range(HEADER_BYTES + size, 1), 0, 0, 0, 1);
                    add_good(pick_serial(), size, 0, 0);
                end
                18, 19:
                    add_noise($urandom_range(6, 1));
                default:
                    add_page(cfg_magic, pick_serial(), size,
                             size + (($urandom_range(3, 0) == 0) ? $urandom_range(4, 1) : 0),
                             0, 1, 0, $urandom_range(5, 0) == 0, $urandom_range(7, 0) != 0);
            endcase
        end
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_MAGIC_WORD)
            cfg_magic = val;
        else
            cfg_max = val[15:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every byte is in and every verdict is out, then let the pipe settle
    task automatic drain();
        while (byte_queue.size() != 0 || bytes_taken != bytes_offered ||
               verdict_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH result %0d %s: got %0h want %0h", results_taken, what, got, want);
        mismatches++;
    endtask

    // Driver: hold the current item until taken, then idle its gap and present the next
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || bytes_taken == bytes_offered))
        begin
            if (byte_queue.size() == 0)
                s_tvalid <= 1'b0;
            else if (send_idle < byte_queue[0].gap)
            begin
                send_idle++;
                s_tvalid <= 1'b0;
            end
            else
            begin
                s_tvalid  <= 1'b1;
                s_tdata   <= byte_queue[0].data;
                s_tuser   <= {byte_queue[0].scan_end, byte_queue[0].first};
                s_tlast   <= byte_queue[0].last;
                void'(byte_queue.pop_front());
                bytes_offered++;
                send_idle = 0;
            end
        end
    end

    // Receiver: random wait per result, calm stretches, and the long hold-off on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (results_taken != rx_seen)
            begin
                rx_seen = results_taken;
                rx_idle = 0;
                if (rx_run == 0)
                begin
                    rx_calm = ($urandom_range(2, 0) == 0);
                    rx_run  = $urandom_range(30, 5);
                end
                rx_run--;
                rx_gap = rx_calm ? 0 : $urandom_range(5, 0);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_idle < rx_gap)
            begin
                rx_idle++;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Monitor: fold accepted bytes into the shadow, check each result against the oldest verdict
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                fold_byte(s_tdata, s_tuser[0], s_tlast, s_tuser[1]);
                bytes_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                results_taken++;
                if (verdict_queue.size() == 0)
                    report_mismatch("with nothing expected", m_tdata[31:0], '0);
                else
                begin
                    verdict_head = verdict_queue.pop_front();
                    if (m_tdata[3:0] != verdict_head.page_number)
                        report_mismatch("page_number", 32'(m_tdata[3:0]),
                                        32'(verdict_head.page_number));
                    if (m_tdata[6:4] != verdict_head.verdict)
                        report_mismatch("verdict", 32'(m_tdata[6:4]),
                                        32'(verdict_head.verdict));
                    if (m_tdata[7] != verdict_head.found)
                        report_mismatch("found", 32'(m_tdata[7]), 32'(verdict_head.found));
                    if (m_tdata[11:8] != verdict_head.best_page)
                        report_mismatch("best_page", 32'(m_tdata[11:8]),
                                        32'(verdict_head.best_page));
                    if (m_tdata[43:12] != verdict_head.lead_serial)
                        report_mismatch("lead_serial", m_tdata[43:12], verdict_head.lead_serial);
                    if (m_tlast != verdict_head.scan_done)
                        report_mismatch("scan_done", 32'(m_tlast), 32'(verdict_head.scan_done));
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no item accepted for %0d cycles", quiet_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        restart_page_state();
        clear_scan_state();
        cfg_magic      = MAGIC_RESET;
        cfg_max        = MAX_PAYLOAD_RESET;
        sender_gap_max = 5;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed pages under the reset register values
        add_page(cfg_magic, 32'h10, 1, 1, 0, 1, 0, 0, 0);           // no page_first after reset
        add_page(cfg_magic, 32'h5, 4, 4, 1, 1, 0, 0, 1);            // first and last on one byte
        add_page(cfg_magic ^ 32'h8000_0000, 32'h3, 2, 2, 0, 1, 0, 0, 1);
        add_page(cfg_magic, 32'h3, 0, 2, 0, 1, 0, 0, 1);            // zero size
        add_page(cfg_magic, 32'h3, {16'b0, cfg_max} + 32'd1, 2, 0, 1, 0, 0, 1);
        add_page(cfg_magic, 32'h3, 32'hFFFF_FFFF, 1, 0, 1, 0, 0, 1);
        add_page(cfg_magic, 32'h3, 8, 3, 0, 1, 0, 0, 1);            // payload cut short
        add_page(cfg_magic, 32'h3, 4, 4, 15, 1, 0, 0, 1);           // header cut short
        add_page(cfg_magic, 32'h3, 4, 4, 16, 1, 0, 0, 1);
        add_page(cfg_magic, 32'h3, 6, 6, 0, 1, 1, 0, 1);            // wrong check
        add_good(32'h10, 4, 6, 0);                                  // bytes past the payload
        add_good(32'h10, 3, 0, 0);                                  // tie keeps earlier page
        add_good(32'hFFFF_FFFF, 2, 0, 0);
        add_good(32'h0, 5, 0, 0);
        add_page(cfg_magic, 32'h7, 8, 8, 10, 0, 0, 0, 1);           // abandoned mid-page
        add_good(32'h11, 8, 0, 0);
        add_good(32'h1, 32'd12, 0, 1);                              // closes scan
        add_good(32'h0, 1, 0, 0);                                   // new scan starts clean
        add_good(32'h2, 3, 0, 1);
        drain();

        // Smallest limits
        write_reg(REG_MAGIC_WORD, 32'h0);
        write_reg(REG_MAX_PAYLOAD, 32'd1);
        add_good(32'h9, 1, 3, 0);
        add_page(cfg_magic, 32'h9, 2, 2, 0, 1, 0, 0, 1);
        run_random(100);
        drain();

        // Largest limits; a header at the largest size passes the size check
        write_reg(REG_MAGIC_WORD, 32'hFFFF_FFFF);
        write_reg(REG_MAX_PAYLOAD, 32'h0000_FFFF);
        sender_gap_max = 0;
        add_page(cfg_magic, 32'hA5A5_5A5A, 32'd65535, 4, 0, 1, 0, 0, 1);
        sender_gap_max = 5;
        add_good(32'h1, 4, 0, 1);
        run_random(100);
        drain();

        // Random settings; hold the receiver off while the sender streams short pages
        write_reg(REG_MAGIC_WORD, $urandom);
        write_reg(REG_MAX_PAYLOAD, 32'($urandom_range(40, 2)));
        hold_requests++;
        sender_gap_max = 0;
        for (int i = 0; i < 12; i++)
            add_good(pick_serial(), $urandom_range(4, 1), 0, $urandom_range(7, 0) == 0);
        sender_gap_max = 5;
        run_random(100);

        drain();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
